// ----- rtl/core/unsigned_decimal_field_formatter_core_assert.svh -----
// Assertion macros shared by the formatter RTL
`ifndef UNSIGNED_DECIMAL_FIELD_FORMATTER_CORE_ASSERT_SVH
`define UNSIGNED_DECIMAL_FIELD_FORMATTER_CORE_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define UDFF_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// ante implies cons in the same cycle
`define UDFF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// ante implies cons in the next cycle
`define UDFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

// ----- rtl/core/udff_pkg.sv -----
// Shared types and constants of the decimal field formatter
package udff_pkg;

    localparam int VALUE_W    = 32;
    localparam int FIELD_W    = 6;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int MAX_DIGITS = 10;
    localparam int DIG_IDX_W  = 4;

    // Divide by ten: q = (t * RECIP_DIV10) >> RECIP_SHIFT, exact for 32-bit t
    localparam logic [VALUE_W-1:0] RECIP_DIV10 = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [CFG_IDX_W-1:0] CFG_FIELD_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION_GIVEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIGITS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_JUSTIFY    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_FILL       = 3'd4;

    typedef struct packed {
        logic load;
        logic conv;
        logic plan;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic skip_conv;
        logic conv_done;
        logic field_empty;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

// ----- rtl/core/udff_dp.sv -----
// Datapath: config registers, digit extraction, field planning, output register
`include "unsigned_decimal_field_formatter_core_assert.svh"

module udff_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  udff_pkg::ctrl_cmd_t            cmd,
    output udff_pkg::dp_status_t           status,
    input  logic [udff_pkg::VALUE_W-1:0]   value,
    input  logic                           cfg_valid,
    input  logic [udff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [udff_pkg::FIELD_W-1:0]   cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [udff_pkg::CHAR_W-1:0]    char_out,
    output logic                           is_last
);
    import udff_pkg::*;

    logic [FIELD_W-1:0] field_width_reg;
    logic               precision_given_reg;
    logic [FIELD_W-1:0] min_digits_reg;
    logic               left_justify_reg;
    logic               zero_fill_reg;

    logic [VALUE_W-1:0]   t_reg;
    logic [DIG_IDX_W-1:0] ndig_reg;
    logic [3:0]           digit_buf [MAX_DIGITS];

    logic [FIELD_W-1:0] pre_reg;
    logic [FIELD_W-1:0] zend_reg;
    logic [FIELD_W-1:0] dend_reg;
    logic [FIELD_W-1:0] total_reg;
    logic [FIELD_W-1:0] pos_reg;
    logic [CHAR_W-1:0]  lead_reg;

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic               last_reg;

    logic [2*VALUE_W-1:0] prod;
    logic [VALUE_W-1:0]   quot;
    logic [VALUE_W-1:0]   quot10;
    logic [VALUE_W-1:0]   rem;

    logic [FIELD_W-1:0]   ndig_ext;
    logic [FIELD_W-1:0]   zpad;
    logic [FIELD_W-1:0]   dig_span;
    logic [FIELD_W-1:0]   spad;
    logic [FIELD_W-1:0]   pre_next;
    logic [FIELD_W-1:0]   dig_off;
    logic [DIG_IDX_W-1:0] dig_idx;
    logic [CHAR_W-1:0]    char_next;

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_width_reg     <= '0;
            precision_given_reg <= 1'b0;
            min_digits_reg      <= '0;
            left_justify_reg    <= 1'b0;
            zero_fill_reg       <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_FIELD_WIDTH:     field_width_reg     <= cfg_data;
                CFG_PRECISION_GIVEN: precision_given_reg <= cfg_data[0];
                CFG_MIN_DIGITS:      min_digits_reg      <= cfg_data;
                CFG_LEFT_JUSTIFY:    left_justify_reg    <= cfg_data[0];
                CFG_ZERO_FILL:       zero_fill_reg       <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    // One decimal digit per cycle through a reciprocal multiply
    assign prod   = t_reg * RECIP_DIV10;
    assign quot   = VALUE_W'(prod >> RECIP_SHIFT);
    assign quot10 = (quot << 3) + (quot << 1);
    assign rem    = t_reg - quot10;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ndig_reg <= '0;
        end
        else if (cmd.load)
        begin
            ndig_reg <= '0;
        end
        else if (cmd.conv)
        begin
            ndig_reg <= ndig_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            t_reg <= value;
        end
        else if (cmd.conv)
        begin
            t_reg              <= quot;
            digit_buf[ndig_reg] <= rem[3:0];
        end
    end

    // Field layout: [lead pad][precision zeros][digits][trailing pad]
    assign ndig_ext = FIELD_W'(ndig_reg);
    assign zpad     = (precision_given_reg && (min_digits_reg > ndig_ext))
                      ? (min_digits_reg - ndig_ext) : '0;
    assign dig_span = ndig_ext + zpad;
    assign spad     = (field_width_reg > dig_span) ? (field_width_reg - dig_span) : '0;
    assign pre_next = left_justify_reg ? '0 : spad;

    always_ff @(posedge clk)
    begin
        if (cmd.plan)
        begin
            pre_reg   <= pre_next;
            zend_reg  <= pre_next + zpad;
            dend_reg  <= pre_next + dig_span;
            total_reg <= dig_span + spad;
            lead_reg  <= (zero_fill_reg && !precision_given_reg) ? CHAR_ZERO : CHAR_SPACE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (cmd.plan)
        begin
            pos_reg <= '0;
        end
        else if (cmd.emit)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

    // Digits were stored least significant first
    assign dig_off = dend_reg - pos_reg - 1'b1;
    assign dig_idx = dig_off[DIG_IDX_W-1:0];

    always_comb
    begin
        priority if (pos_reg < pre_reg)
        begin
            char_next = lead_reg;
        end
        else if (pos_reg < zend_reg)
        begin
            char_next = CHAR_ZERO;
        end
        else if (pos_reg < dend_reg)
        begin
            char_next = CHAR_ZERO + CHAR_W'(digit_buf[dig_idx]);
        end
        else
        begin
            char_next = CHAR_SPACE;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            char_reg <= char_next;
            last_reg <= status.emit_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign char_out  = char_reg;
    assign is_last   = last_reg;

    assign status.skip_conv   = (value == '0) && precision_given_reg && (min_digits_reg == '0);
    assign status.conv_done   = (quot == '0) || (ndig_reg == DIG_IDX_W'(MAX_DIGITS - 1));
    assign status.field_empty = (total_reg == '0);
    assign status.emit_last   = (pos_reg == total_reg - 1'b1);
    assign status.out_free    = !out_valid_reg || out_ready;

    `UDFF_ASSERT_ALWAYS(a_ndig_bound, clk, rst_n, ndig_reg <= DIG_IDX_W'(MAX_DIGITS), "%m: digit count overflow")
    `UDFF_ASSERT_SAME(a_emit_in_field, clk, rst_n, cmd.emit, pos_reg < total_reg)
endmodule

// ----- rtl/core/udff_ctrl.sv -----
// Controller: sequences load, digit extraction, planning and character output
`include "unsigned_decimal_field_formatter_core_assert.svh"

module udff_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  udff_pkg::dp_status_t  status,
    output udff_pkg::ctrl_cmd_t   cmd
);
    import udff_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PLAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.skip_conv ? ST_PLAN : ST_CONV;
                end
            end
            ST_CONV:
            begin
                cmd.conv = 1'b1;
                if (status.conv_done)
                begin
                    state_next = ST_PLAN;
                end
            end
            ST_PLAN:
            begin
                cmd.plan   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Drop an empty field without output
                if (status.field_empty)
                begin
                    state_next = ST_IDLE;
                end
                else if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    `UDFF_ASSERT_NEXT(a_conv_exit, clk, rst_n, state_reg == ST_CONV, state_reg == ST_CONV || state_reg == ST_PLAN)
endmodule

// ----- rtl/core/unsigned_decimal_field_formatter_core.sv -----
// Top level of the unsigned decimal field formatter
//
// Formats a 32-bit unsigned value as a printf %u field, one ASCII character
// per output item, most significant first; is_last marks the final character.
// Input channel: in_valid/in_ready with value. Output channel: out_valid/
// out_ready with char_out and is_last. Config channel: cfg_valid/cfg_ready
// with cfg_index (0 width, 1 precision given, 2 min digits, 3 left justify,
// 4 zero fill) and cfg_data; cfg_ready is always high, other indexes ignored.
// Sequence: a load step, then extraction of the decimal digits (1 to 10, none
// for a zero with precision 0) through a shared divide-by-ten multiplier, a
// planning step, then one character per cycle into the output register
// while the receiver keeps up; a field with no characters returns the block
// to idle with no output.
// The next value is accepted once the last character sits in the output
// register. A receiver stall holds the output register and pauses the field.
// Reset clears all configuration to 0 and returns the block to idle with no
// output pending.
module unsigned_decimal_field_formatter_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [udff_pkg::VALUE_W-1:0]   value,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [udff_pkg::CHAR_W-1:0]    char_out,
    output logic                           is_last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [udff_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [udff_pkg::FIELD_W-1:0]   cfg_data
);
    import udff_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    udff_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    udff_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .is_last   (is_last)
    );
endmodule

// ----- test/tb.sv -----
// Testbench of the unsigned decimal field formatter: directed and random fields checked against a predictor
`timescale 1ns / 1ps

module tb;
    import udff_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_ITEMS   = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_ZERO_FILL + 1'b1;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } field_char_t;

    class field_scoreboard;
        logic [FIELD_W-1:0] width_r;
        logic               prec_on;
        logic [FIELD_W-1:0] prec_r;
        logic               left_r;
        logic               zfill_r;
        field_char_t        due[$];
        int                 errors;

        function new();
            width_r = '0;
            prec_on = 1'b0;
            prec_r  = '0;
            left_r  = 1'b0;
            zfill_r = 1'b0;
            errors  = 0;
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] data);
            case (idx)
                CFG_FIELD_WIDTH:     width_r = data;
                CFG_PRECISION_GIVEN: prec_on = data[0];
                CFG_MIN_DIGITS:      prec_r  = data;
                CFG_LEFT_JUSTIFY:    left_r  = data[0];
                CFG_ZERO_FILL:       zfill_r = data[0];
                default: ;
            endcase
        endfunction

        function void push_char(logic [CHAR_W-1:0] ch);
            field_char_t fc;
            fc.ch   = ch;
            fc.last = 1'b0;
            due.push_back(fc);
        endfunction

        // expand one value into the characters of its field
        function void note_value(logic [VALUE_W-1:0] v);
            logic [CHAR_W-1:0]  digs[MAX_DIGITS];
            logic [VALUE_W-1:0] t;
            logic [CHAR_W-1:0]  lead;
            int ndig, zpad, spad, first, w, p;
            ndig  = 0;
            w     = width_r;
            p     = prec_r;
            first = due.size();
            if (!(v == 0 && prec_on && p == 0)) begin
                t = v;
                do begin
                    digs[ndig] = CHAR_ZERO + 8'(t % 10);
                    ndig++;
                    t = t / 10;
                end while (t != 0);
            end
            zpad = (prec_on && p > ndig) ? p - ndig : 0;
            spad = (w > ndig + zpad) ? w - ndig - zpad : 0;
            lead = (zfill_r && !prec_on) ? CHAR_ZERO : CHAR_SPACE;
            if (!left_r)
                repeat (spad) push_char(lead);
            repeat (zpad) push_char(CHAR_ZERO);
            for (int i = ndig - 1; i >= 0; i--)
                push_char(digs[i]);
            if (left_r)
                repeat (spad) push_char(CHAR_SPACE);
            if (due.size() > first)
                due[$].last = 1'b1;
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            field_char_t fc;
            if (due.size() == 0) begin
                $error("char_out %h (is_last %b) arrived with nothing expected", ch, last);
                errors++;
                return;
            end
            fc = due.pop_front();
            if (ch !== fc.ch) begin
                $error("char_out mismatch: expected %h, got %h", fc.ch, ch);
                errors++;
            end
            if (last !== fc.last) begin
                $error("is_last mismatch: expected %b, got %b", fc.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [VALUE_W-1:0]   value = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CHAR_W-1:0]    char_out;
    logic                 is_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FIELD_W-1:0]   cfg_data = '0;

    field_scoreboard board;
    bit in_idle  = 1'b1;
    bit out_idle = 1'b1;
    int in_gap   = 0;
    bit in_held  = 1'b0;

    unsigned_decimal_field_formatter_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .char_out  (char_out),
        .is_last   (is_last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: in idle phases, stall a random number of cycles before each item
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            stall = out_idle ? $urandom_range(0, 10) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            board.check_char(char_out, is_last);
        end
    end

    // keep in_valid high when the next item follows with no gap
    task automatic send_value(input logic [VALUE_W-1:0] v);
        if (in_gap > 0)
            repeat (in_gap) @(posedge clk);
        in_valid <= 1'b1;
        value    <= v;
        do @(posedge clk); while (!in_ready);
        board.note_value(v);
        in_gap  = in_idle ? $urandom_range(0, 10) : 0;
        in_held = (in_gap == 0);
        if (!in_held)
            in_valid <= 1'b0;
    endtask

    task automatic pause_until_drained();
        if (in_held)
            in_valid <= 1'b0;
        in_held = 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // hold off until the block is idle, allowing for fields with no characters
    task automatic settle();
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FIELD_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        board.note_write(idx, data);
    endtask

    // one-bit registers get random junk in their upper data bits
    task automatic apply_config(input logic [FIELD_W-1:0] w, input logic pg,
                                input logic [FIELD_W-1:0] md, input logic lj, input logic zf);
        write_reg(CFG_FIELD_WIDTH, w);
        write_reg(CFG_PRECISION_GIVEN, {5'($urandom), pg});
        write_reg(CFG_MIN_DIGITS, md);
        write_reg(CFG_LEFT_JUSTIFY, {5'($urandom), lj});
        write_reg(CFG_ZERO_FILL, {5'($urandom), zf});
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_SPARE_LO + 3'($urandom_range(0, 2)), 6'($urandom));
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] draw_size();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 6'd63;
            2:       return 6'($urandom_range(0, 63));
            default: return 6'($urandom_range(1, 14));
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] draw_value();
        logic [VALUE_W-1:0] p;
        p = 1;
        case ($urandom_range(0, 4))
            0: return VALUE_W'($urandom_range(0, 9));
            1: return VALUE_W'($urandom_range(0, 99999));
            2:
            begin
                // straddle a power of ten
                repeat ($urandom_range(1, 9)) p = p * 10;
                return p - VALUE_W'($urandom_range(0, 1));
            end
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        board = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: plain %u
        send_value(32'd0);
        send_value(32'd9);
        send_value(32'd10);
        send_value(32'hFFFF_FFFF);
        send_value(32'd1_000_000_000);
        settle();
        // widest field, precision wins over zero fill
        apply_config(6'd63, 1'b1, 6'd63, 1'b0, 1'b1);
        send_value(32'd0);
        send_value(32'hFFFF_FFFF);
        settle();
        // zero with precision 0 and width 0 prints nothing
        apply_config(6'd0, 1'b1, 6'd0, 1'b0, 1'b0);
        send_value(32'd0);
        send_value(32'd0);
        send_value(32'd5);
        settle();
        // left justify overrides zero fill
        apply_config(6'd12, 1'b0, 6'd0, 1'b1, 1'b1);
        send_value(32'd42);
        send_value(32'd0);
        settle();
        apply_config(6'd20, 1'b0, 6'd0, 1'b0, 1'b1);
        send_value(32'd3_000_000_000);
        send_value(32'd0);
        settle();
        apply_config(6'd5, 1'b1, 6'd8, 1'b1, 1'b0);
        send_value(32'd77);
        send_value(32'd123_456_789);
        settle();
        apply_config(6'd63, 1'b0, 6'd0, 1'b1, 1'b0);
        send_value(32'd1);
        settle();
        // writes to unused indexes must not disturb the empty-field setting
        apply_config(6'd0, 1'b1, 6'd0, 1'b0, 1'b0);
        @(posedge clk);
        write_reg(CFG_SPARE_LO, 6'h3F);
        write_reg(CFG_SPARE_LO + 3'd1, 6'h2A);
        write_reg(CFG_SPARE_LO + 3'd2, 6'h15);
        cfg_valid <= 1'b0;
        send_value(32'd0);

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            apply_config(draw_size(), 1'($urandom), draw_size(), 1'($urandom), 1'($urandom));
            in_idle  = (phase % 4 == 0) || (phase % 4 == 1);
            out_idle = (phase % 4 == 0) || (phase % 4 == 2);
            in_gap   = in_idle ? $urandom_range(0, 10) : 0;
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                if (k == PHASE_ITEMS / 2 && phase % 2 == 1)
                    pause_until_drained();
                send_value(draw_value());
            end
        end

        settle();
        if (board.errors == 0 && board.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/udff_pkg.sv
rtl/core/udff_dp.sv
rtl/core/udff_ctrl.sv
rtl/core/unsigned_decimal_field_formatter_core.sv
test/tb.sv
